/* rtl/wrp_pkg.sv */
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants of the WAV RIFF header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wrp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    typedef enum logic [1:0] {
        EV_FORMAT  = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_BAD_TAG = 2'd2,
        EV_BAD_FMT = 2'd3
    } event_t;

    typedef enum logic [3:0] {
        OP_CLEAR    = 4'd0,
        OP_CH_LO    = 4'd1,
        OP_CH_HI    = 4'd2,
        OP_RATE0    = 4'd3,
        OP_RATE1    = 4'd4,
        OP_RATE2    = 4'd5,
        OP_RATE3    = 4'd6,
        OP_DEPTH_LO = 4'd7,
        OP_DEPTH_HI = 4'd8,
        OP_FORMAT   = 4'd9,
        OP_PAYLOAD  = 4'd10,
        OP_BAD_TAG  = 4'd11,
        OP_BAD_FMT  = 4'd12
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic        last;
        logic [31:0] length;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/wrp_if.sv */
// ----------------------------------------------------------------------------
// wrp_byte_if / wrp_result_if
// Valid/ready channels of the WAV RIFF header parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_start;

    modport source (output valid, output in_byte, output file_start, input ready);
    modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

interface wrp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [12:0] bytes_per_sample;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_payload;

    modport source (output valid, output event_res, output rate_hz,
                    output channel_count, output bytes_per_sample,
                    output payload_length, output payload_byte,
                    output last_payload, input ready);
    modport sink   (input valid, input event_res, input rate_hz,
                    input channel_count, input bytes_per_sample,
                    input payload_length, input payload_byte,
                    input last_payload, output ready);
endinterface

`default_nettype wire

/* rtl/wav_riff_header_parser_unit.sv */
// ----------------------------------------------------------------------------
// wav_riff_header_parser_unit
// WAV RIFF header parser with payload pass-through.
//
// Input channel wav: one file byte per item; file_start marks byte 0 of a
// new file and restarts parsing. Output channel result: format, payload
// and tag-error events.
// A front parser classifies each byte into a command, a two-entry queue
// decouples it from the back end, which captures format fields and loads
// the output register. One byte is taken per cycle while the queue is not
// full; a byte that yields an event is written to the queue when it is
// accepted, moves from the queue head into the output register, and is
// then offered on result. Sustained rate is one item per cycle while result
// does not stall, set by the single-byte parser step.
// Reset returns the parser to waiting for a file start, empties the queue
// and clears the output valid. When result stalls, the output register
// holds its event, the queue fills and wav.ready falls once two commands
// are waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_riff_header_parser_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    wrp_byte_if.sink     wav,
    wrp_result_if.source result
);
    import wrp_pkg::*;

    logic cmd_valid;
    logic q_not_full;
    cmd_t front_cmd;
    logic head_valid;
    logic pop;
    cmd_t head_cmd;

    wrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (wav.valid),
        .byte_ready (wav.ready),
        .in_byte    (wav.in_byte),
        .file_start (wav.file_start),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (q_not_full),
        .cmd        (front_cmd)
    );

    wrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_valid),
        .not_full   (q_not_full),
        .push_cmd   (front_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .head_cmd   (head_cmd)
    );

    wrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

/* rtl/wrp_front.sv */
// ----------------------------------------------------------------------------
// wrp_front
// Parses the byte stream and issues commands to the back end for file starts, format fields, payload and tag errors.
// ----------------------------------------------------------------------------
`default_nettype none

module wrp_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_ready,
    input  wire logic [7:0]   in_byte,
    input  wire logic         file_start,
    output logic              cmd_valid,
    input  wire logic         cmd_ready,
    output wrp_pkg::cmd_t     cmd
);
    import wrp_pkg::*;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_HEADER    = 4'd1;
    localparam logic [3:0] PH_FMT_TAG   = 4'd2;
    localparam logic [3:0] PH_FMT_SIZE  = 4'd3;
    localparam logic [3:0] PH_FMT_BODY  = 4'd4;
    localparam logic [3:0] PH_CHUNK_ID  = 4'd5;
    localparam logic [3:0] PH_SKIP_SIZE = 4'd6;
    localparam logic [3:0] PH_SKIP_BODY = 4'd7;
    localparam logic [3:0] PH_DATA_SIZE = 4'd8;
    localparam logic [3:0] PH_PAYLOAD   = 4'd9;

    logic [3:0]  phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] rem_reg, rem_next;

    logic [3:0]  ph;
    logic [4:0]  pos;
    logic [31:0] len;
    logic [31:0] rem;
    logic [31:0] tag_shifted;
    logic [31:0] len_byte;
    logic        has_cmd;
    logic        accept;

    assign byte_ready = cmd_ready;
    assign accept     = byte_valid && byte_ready;
    assign cmd_valid  = accept && has_cmd;

    always_comb
    begin
        ph  = phase_reg;
        pos = pos_reg;
        len = len_reg;
        rem = rem_reg;
        has_cmd = 1'b0;
        cmd = '{op: OP_CLEAR, data: in_byte, last: 1'b0, length: 32'd0};
        if (file_start)
        begin
            ph  = PH_HEADER;
            pos = 5'd0;
            len = 32'd0;
            rem = 32'd0;
            has_cmd = 1'b1;
        end

        tag_shifted = {tag_reg[23:0], in_byte};
        len_byte = len;
        unique case (pos[1:0])
            2'd0: len_byte[7:0]   = in_byte;
            2'd1: len_byte[15:8]  = in_byte;
            2'd2: len_byte[23:16] = in_byte;
            2'd3: len_byte[31:24] = in_byte;
        endcase

        phase_next = ph;
        pos_next   = pos;
        tag_next   = tag_reg;
        len_next   = len;
        rem_next   = rem;

        unique case (ph)
            PH_IDLE:
            begin
            end
            PH_HEADER:
            begin
                tag_next = tag_shifted;
                if ((pos == 5'd3 && tag_shifted != TAG_RIFF) ||
                    (pos == 5'd11 && tag_shifted != TAG_WAVE))
                begin
                    phase_next = PH_IDLE;
                    has_cmd = 1'b1;
                    cmd.op = OP_BAD_TAG;
                end
                else if (pos == 5'd11)
                begin
                    pos_next   = 5'd0;
                    phase_next = PH_FMT_TAG;
                end
                else
                begin
                    pos_next = pos + 5'd1;
                end
            end
            PH_FMT_TAG:
            begin
                tag_next = tag_shifted;
                if (pos == 5'd3)
                begin
                    pos_next = 5'd0;
                    len_next = 32'd0;
                    if (tag_shifted != TAG_FMT)
                    begin
                        phase_next = PH_IDLE;
                        has_cmd = 1'b1;
                        cmd.op = OP_BAD_FMT;
                    end
                    else
                    begin
                        phase_next = PH_FMT_SIZE;
                    end
                end
                else
                begin
                    pos_next = pos + 5'd1;
                end
            end
            PH_FMT_SIZE, PH_SKIP_SIZE:
            begin
                len_next = len_byte;
                if (pos == 5'd3)
                begin
                    pos_next = 5'd0;
                    rem_next = len_byte;
                    if (len_byte == 32'd0)
                        phase_next = PH_CHUNK_ID;
                    else if (ph == PH_FMT_SIZE)
                        phase_next = PH_FMT_BODY;
                    else
                        phase_next = PH_SKIP_BODY;
                end
                else
                begin
                    pos_next = pos + 5'd1;
                end
            end
            PH_FMT_BODY:
            begin
                has_cmd = 1'b1;
                unique case (pos)
                    5'd2:    cmd.op = OP_CH_LO;
                    5'd3:    cmd.op = OP_CH_HI;
                    5'd4:    cmd.op = OP_RATE0;
                    5'd5:    cmd.op = OP_RATE1;
                    5'd6:    cmd.op = OP_RATE2;
                    5'd7:    cmd.op = OP_RATE3;
                    5'd14:   cmd.op = OP_DEPTH_LO;
                    5'd15:   cmd.op = OP_DEPTH_HI;
                    default: has_cmd = file_start;
                endcase
                pos_next = (pos == 5'd16) ? pos : pos + 5'd1;
                rem_next = rem - 32'd1;
                if (rem == 32'd1)
                begin
                    pos_next   = 5'd0;
                    phase_next = PH_CHUNK_ID;
                end
            end
            PH_CHUNK_ID:
            begin
                tag_next = tag_shifted;
                if (pos == 5'd3)
                begin
                    pos_next   = 5'd0;
                    len_next   = 32'd0;
                    phase_next = (tag_shifted == TAG_DATA) ? PH_DATA_SIZE : PH_SKIP_SIZE;
                end
                else
                begin
                    pos_next = pos + 5'd1;
                end
            end
            PH_SKIP_BODY:
            begin
                rem_next = rem - 32'd1;
                if (rem == 32'd1)
                    phase_next = PH_CHUNK_ID;
            end
            PH_DATA_SIZE:
            begin
                len_next = len_byte;
                if (pos == 5'd3)
                begin
                    pos_next   = 5'd0;
                    rem_next   = len_byte;
                    phase_next = (len_byte == 32'd0) ? PH_IDLE : PH_PAYLOAD;
                    has_cmd    = 1'b1;
                    cmd.op     = OP_FORMAT;
                    cmd.length = len_byte;
                end
                else
                begin
                    pos_next = pos + 5'd1;
                end
            end
            PH_PAYLOAD:
            begin
                rem_next = rem - 32'd1;
                has_cmd  = 1'b1;
                cmd.op   = OP_PAYLOAD;
                cmd.last = (rem == 32'd1);
                if (rem == 32'd1)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 5'd0;
            tag_reg   <= 32'd0;
            len_reg   <= 32'd0;
            rem_reg   <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
        end
    end

    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> pos_reg < 5'd12)
        else $error("header position out of range");

    a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FMT_BODY || phase_reg == PH_SKIP_BODY ||
         phase_reg == PH_PAYLOAD) |-> rem_reg != 32'd0)
        else $error("chunk body with nothing left");

    a_size_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FMT_SIZE || phase_reg == PH_SKIP_SIZE ||
         phase_reg == PH_DATA_SIZE || phase_reg == PH_CHUNK_ID ||
         phase_reg == PH_FMT_TAG) |-> pos_reg < 5'd4)
        else $error("size or tag position out of range");

endmodule

`default_nettype wire

/* rtl/wrp_queue.sv */
// ----------------------------------------------------------------------------
// wrp_queue
// Two-entry command queue between the parser front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wrp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               not_full,
    input  wire wrp_pkg::cmd_t push_cmd,
    output logic               head_valid,
    input  wire logic          pop,
    output wrp_pkg::cmd_t      head_cmd
);
    import wrp_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_full    = (count_reg != 2'd2);
    assign head_valid  = (count_reg != 2'd0);
    assign head_cmd    = entry_reg[rd_ptr_reg];
    assign wr_ptr_next = wr_ptr_reg ^ push;
    assign rd_ptr_next = rd_ptr_reg ^ pop;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/wrp_back.sv */
// ----------------------------------------------------------------------------
// wrp_back
// Executes queued commands: captures format fields and drives the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire wrp_pkg::cmd_t head_cmd,
    output logic               pop,
    wrp_result_if.source       result
);
    import wrp_pkg::*;

    logic [31:0] rate_reg, rate_next;
    logic [15:0] ch_reg, ch_next;
    logic [15:0] depth_reg, depth_next;
    logic [31:0] plen_reg, plen_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  ev_reg, ev_next;
    logic [31:0] o_rate_reg, o_rate_next;
    logic [15:0] o_ch_reg, o_ch_next;
    logic [12:0] o_bps_reg, o_bps_next;
    logic [31:0] o_len_reg, o_len_next;
    logic [7:0]  o_byte_reg, o_byte_next;
    logic        o_last_reg, o_last_next;

    logic emits;
    logic out_free;

    assign emits    = (head_cmd.op == OP_FORMAT) || (head_cmd.op == OP_PAYLOAD) ||
                      (head_cmd.op == OP_BAD_TAG) || (head_cmd.op == OP_BAD_FMT);
    assign out_free = !out_valid_reg || result.ready;
    assign pop      = head_valid && (!emits || out_free);

    always_comb
    begin
        rate_next      = rate_reg;
        ch_next        = ch_reg;
        depth_next     = depth_reg;
        plen_next      = plen_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ev_next        = ev_reg;
        o_rate_next    = o_rate_reg;
        o_ch_next      = o_ch_reg;
        o_bps_next     = o_bps_reg;
        o_len_next     = o_len_reg;
        o_byte_next    = o_byte_reg;
        o_last_next    = o_last_reg;
        if (pop)
        begin
            unique case (head_cmd.op)
                OP_CLEAR:
                begin
                    rate_next  = 32'd0;
                    ch_next    = 16'd0;
                    depth_next = 16'd0;
                end
                OP_CH_LO:    ch_next[7:0]     = head_cmd.data;
                OP_CH_HI:    ch_next[15:8]    = head_cmd.data;
                OP_RATE0:    rate_next[7:0]   = head_cmd.data;
                OP_RATE1:    rate_next[15:8]  = head_cmd.data;
                OP_RATE2:    rate_next[23:16] = head_cmd.data;
                OP_RATE3:    rate_next[31:24] = head_cmd.data;
                OP_DEPTH_LO: depth_next[7:0]  = head_cmd.data;
                OP_DEPTH_HI: depth_next[15:8] = head_cmd.data;
                OP_FORMAT, OP_PAYLOAD:
                begin
                    out_valid_next = 1'b1;
                    o_rate_next    = rate_reg;
                    o_ch_next      = ch_reg;
                    o_bps_next     = depth_reg[15:3];
                    if (head_cmd.op == OP_FORMAT)
                    begin
                        plen_next   = head_cmd.length;
                        ev_next     = EV_FORMAT;
                        o_len_next  = head_cmd.length;
                        o_byte_next = 8'd0;
                        o_last_next = 1'b0;
                    end
                    else
                    begin
                        ev_next     = EV_PAYLOAD;
                        o_len_next  = plen_reg;
                        o_byte_next = head_cmd.data;
                        o_last_next = head_cmd.last;
                    end
                end
                OP_BAD_TAG, OP_BAD_FMT:
                begin
                    out_valid_next = 1'b1;
                    ev_next        = (head_cmd.op == OP_BAD_TAG) ? EV_BAD_TAG : EV_BAD_FMT;
                    o_rate_next    = 32'd0;
                    o_ch_next      = 16'd0;
                    o_bps_next     = 13'd0;
                    o_len_next     = 32'd0;
                    o_byte_next    = 8'd0;
                    o_last_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rate_reg      <= 32'd0;
            ch_reg        <= 16'd0;
            depth_reg     <= 16'd0;
            plen_reg      <= 32'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rate_reg      <= rate_next;
            ch_reg        <= ch_next;
            depth_reg     <= depth_next;
            plen_reg      <= plen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg     <= ev_next;
        o_rate_reg <= o_rate_next;
        o_ch_reg   <= o_ch_next;
        o_bps_reg  <= o_bps_next;
        o_len_reg  <= o_len_next;
        o_byte_reg <= o_byte_next;
        o_last_reg <= o_last_next;
    end

    assign result.valid            = out_valid_reg;
    assign result.event_res        = ev_reg;
    assign result.rate_hz          = o_rate_reg;
    assign result.channel_count    = o_ch_reg;
    assign result.bytes_per_sample = o_bps_reg;
    assign result.payload_length   = o_len_reg;
    assign result.payload_byte     = o_byte_reg;
    assign result.last_payload     = o_last_reg;

    a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ev_reg != EV_PAYLOAD) |-> !o_last_reg)
        else $error("last flag on non-payload event");

endmodule

`default_nettype wire
